// File: rtl/core/tvmp_pkg.sv
// Package for the tag=value message parser: widths, byte codes, tag codes,
// phase codes, the parser state and result structs, and decimal helpers.
// No dependencies.
`timescale 1ns / 1ps

package tvmp_pkg;

  localparam int RAW_LEN_BITS = 16;
  localparam int TAG_BITS     = 20;
  localparam int FIELD_TAG_W  = 20;
  localparam int RX_CK_W      = 10;

  localparam logic [TAG_BITS-1:0]     TAG_MAX = {TAG_BITS{1'b1}};
  localparam logic [RAW_LEN_BITS-1:0] LEN_MAX = {RAW_LEN_BITS{1'b1}};

  localparam logic [TAG_BITS-1:0] TAG_RAW_LEN  = TAG_BITS'(95);
  localparam logic [TAG_BITS-1:0] TAG_CHECKSUM = TAG_BITS'(10);

  localparam logic [7:0] SOH_BYTE   = 8'h01;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [RX_CK_W-1:0] RX_CK_MAX = RX_CK_W'(999);

  // parser phase codes
  localparam logic [1:0] PH_SKIP  = 2'd0;
  localparam logic [1:0] PH_TAG   = 2'd1;
  localparam logic [1:0] PH_VALUE = 2'd2;
  localparam logic [1:0] PH_RAW   = 2'd3;

  typedef struct packed {
    logic [1:0]              phase;
    logic [TAG_BITS-1:0]     tag_acc;
    logic [RAW_LEN_BITS-1:0] value_num;
    logic                    value_stop;
    logic [RAW_LEN_BITS-1:0] raw_rem;
    logic                    raw_pend;
    logic [7:0]              msg_sum;
    logic [7:0]              fld_sum;
  } parse_state_t;

  typedef struct packed {
    logic                   value_valid;
    logic                   field_end;
    logic                   message_end;
    logic [FIELD_TAG_W-1:0] field_tag;
    logic [7:0]             value_byte;
    logic                   raw_value;
    logic [7:0]             computed_checksum;
    logic [RX_CK_W-1:0]     received_checksum;
    logic                   checksum_ok;
  } result_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CHAR_ZERO) && (b <= CHAR_NINE);
  endfunction

  // t*10 + digit, saturating
  function automatic logic [TAG_BITS-1:0] tag_mac(input logic [TAG_BITS-1:0] t,
                                                  input logic [7:0] b);
    logic [TAG_BITS+3:0] w;
    logic [TAG_BITS+3:0] s;
    w = (TAG_BITS+4)'(t);
    s = (w << 3) + (w << 1) + (TAG_BITS+4)'(b - CHAR_ZERO);
    return (s > (TAG_BITS+4)'(TAG_MAX)) ? TAG_MAX : s[TAG_BITS-1:0];
  endfunction

  function automatic logic [RAW_LEN_BITS-1:0] num_mac(
      input logic [RAW_LEN_BITS-1:0] n, input logic [7:0] b);
    logic [RAW_LEN_BITS+3:0] w;
    logic [RAW_LEN_BITS+3:0] s;
    w = (RAW_LEN_BITS+4)'(n);
    s = (w << 3) + (w << 1) + (RAW_LEN_BITS+4)'(b - CHAR_ZERO);
    return (s > (RAW_LEN_BITS+4)'(LEN_MAX)) ? LEN_MAX : s[RAW_LEN_BITS-1:0];
  endfunction

endpackage

// File: rtl/core/tvmp_byte_if.sv
// Input channel: one received byte per beat, valid/ready handshake.
// Depends on nothing.
`timescale 1ns / 1ps

interface tvmp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

// File: rtl/core/tvmp_result_if.sv
// Result channel: one parser result per beat, valid/ready handshake.
// Depends on tvmp_pkg for field widths.
`timescale 1ns / 1ps

interface tvmp_result_if
  import tvmp_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic                   value_valid;
  logic                   field_end;
  logic                   message_end;
  logic [FIELD_TAG_W-1:0] field_tag;
  logic [7:0]             value_byte;
  logic                   raw_value;
  logic [7:0]             computed_checksum;
  logic [RX_CK_W-1:0]     received_checksum;
  logic                   checksum_ok;

  modport source (output valid, output value_valid, output field_end,
                  output message_end, output field_tag, output value_byte,
                  output raw_value, output computed_checksum,
                  output received_checksum, output checksum_ok, input ready);
  modport sink   (input valid, input value_valid, input field_end,
                  input message_end, input field_tag, input value_byte,
                  input raw_value, input computed_checksum,
                  input received_checksum, input checksum_ok, output ready);
endinterface

// File: rtl/core/tvmp_step.sv
// One-byte step of the parser: next state and optional result from the
// current state and one byte. Purely combinational. Depends on tvmp_pkg.
`timescale 1ns / 1ps

module tvmp_step
  import tvmp_pkg::*;
(
  input  parse_state_t cur,
  input  logic [7:0]   data_byte,
  output parse_state_t nxt,
  output result_t      res,
  output logic         has_result
);

  logic                    digit;
  logic [7:0]              fsum_upd;
  logic [RAW_LEN_BITS-1:0] num_upd;
  logic                    stop_upd;
  logic [RAW_LEN_BITS-1:0] rem_dec;
  logic [RAW_LEN_BITS-1:0] end_num;
  logic                    ended;
  logic                    is_ck;
  logic [RX_CK_W-1:0]      rx_ck;

  always_comb begin
    digit    = is_digit(data_byte);
    fsum_upd = cur.fld_sum + data_byte;
    rem_dec  = cur.raw_rem - RAW_LEN_BITS'(1);
    is_ck    = (cur.tag_acc == TAG_CHECKSUM);

    // value number stops at the first non-digit
    num_upd  = cur.value_num;
    stop_upd = cur.value_stop;
    if (!cur.value_stop) begin
      if (digit) begin
        num_upd = num_mac(cur.value_num, data_byte);
      end else begin
        stop_upd = 1'b1;
      end
    end

    nxt        = cur;
    res        = '0;
    has_result = 1'b0;
    ended      = 1'b0;
    end_num    = cur.value_num;

    case (cur.phase)
      PH_SKIP: begin
        if (!digit) begin
          nxt.msg_sum = cur.msg_sum + data_byte;
        end else begin
          nxt.tag_acc    = TAG_BITS'(data_byte - CHAR_ZERO);
          nxt.fld_sum    = data_byte;
          nxt.value_num  = '0;
          nxt.value_stop = 1'b0;
          nxt.phase      = PH_TAG;
        end
      end
      PH_TAG: begin
        nxt.fld_sum = fsum_upd;
        if (digit) begin
          nxt.tag_acc = tag_mac(cur.tag_acc, data_byte);
        end else if (cur.raw_pend) begin
          if (cur.raw_rem == '0) begin
            // empty raw field ends on the tag terminator
            has_result    = 1'b1;
            ended         = 1'b1;
            res.raw_value = 1'b1;
          end else begin
            nxt.phase = PH_RAW;
          end
        end else begin
          nxt.phase = PH_VALUE;
        end
      end
      PH_VALUE: begin
        nxt.fld_sum = fsum_upd;
        has_result  = 1'b1;
        if (data_byte == SOH_BYTE) begin
          ended = 1'b1;
        end else begin
          nxt.value_num   = num_upd;
          nxt.value_stop  = stop_upd;
          res.value_valid = 1'b1;
          res.value_byte  = data_byte;
        end
      end
      default: begin
        nxt.fld_sum     = fsum_upd;
        nxt.value_num   = num_upd;
        nxt.value_stop  = stop_upd;
        nxt.raw_rem     = rem_dec;
        end_num         = num_upd;
        has_result      = 1'b1;
        res.value_valid = 1'b1;
        res.value_byte  = data_byte;
        res.raw_value   = 1'b1;
        ended           = (rem_dec == '0);
      end
    endcase

    res.field_tag = FIELD_TAG_W'(cur.tag_acc);
    res.field_end = ended;

    rx_ck = (32'(end_num) > 32'(RX_CK_MAX)) ? RX_CK_MAX : RX_CK_W'(end_num);

    if (ended) begin
      nxt.phase = PH_SKIP;
      if (is_ck) begin
        res.message_end       = 1'b1;
        res.computed_checksum = cur.msg_sum;
        res.received_checksum = rx_ck;
        res.checksum_ok       = (rx_ck == RX_CK_W'(cur.msg_sum));
        nxt.msg_sum           = '0;
        nxt.raw_pend          = 1'b0;
      end else begin
        nxt.msg_sum = cur.msg_sum + fsum_upd;
        if (cur.tag_acc == TAG_RAW_LEN) begin
          nxt.raw_pend = 1'b1;
          nxt.raw_rem  = end_num;
        end else begin
          nxt.raw_pend = 1'b0;
        end
      end
    end
  end

endmodule

// File: rtl/core/tag_value_message_parser_top.sv
// Top level of the tag=value message parser with checksum check.
// Depends on tvmp_pkg, tvmp_byte_if, tvmp_result_if and tvmp_step.
`timescale 1ns / 1ps
//
//  channel     dir  payload                                   beat
//  byte_in     in   data_byte[7:0]                            one stream byte
//  result_out  out  value_valid, field_end, message_end,      one result
//                   field_tag[19:0], value_byte[7:0],
//                   raw_value, computed/received checksum,
//                   checksum_ok
//
//  Throughput: one byte per cycle while result_out does not stall. An
//  accepted byte passes the input register, then the result register.
//  The parser state updates in the same cycle the byte leaves the input
//  register, so consecutive bytes never wait on each other.
//  Skipped and tag bytes give no result (bar an empty raw field's end).
//  Reset (rst, synchronous) clears the parser state and both valid flags.
//  A stalled result_out holds the result register; the input register then
//  fills and byte_in.ready drops until the result is taken.

module tag_value_message_parser_top
  import tvmp_pkg::*;
(
  input logic           clk,
  input logic           rst,
  tvmp_byte_if.sink     byte_in,
  tvmp_result_if.source result_out
);

  // input register
  logic       in_valid;
  logic [7:0] in_byte;

  // parser state
  parse_state_t state;
  parse_state_t state_next;

  // result register
  logic    res_valid;
  result_t res;
  result_t step_res;
  logic    step_has;

  logic advance;

  // the byte in the input register moves on when the result slot is free
  assign advance       = in_valid && (!res_valid || result_out.ready);
  assign byte_in.ready = !in_valid || advance;

  tvmp_step u_step (
    .cur        (state),
    .data_byte  (in_byte),
    .nxt        (state_next),
    .res        (step_res),
    .has_result (step_has)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (byte_in.ready) begin
      in_valid <= byte_in.valid;
    end
    if (byte_in.valid && byte_in.ready) begin
      in_byte <= byte_in.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (!res_valid || result_out.ready) begin
      res_valid <= advance && step_has;
    end
    if (advance && step_has) begin
      res <= step_res;
    end
  end

  assign result_out.valid             = res_valid;
  assign result_out.value_valid       = res.value_valid;
  assign result_out.field_end         = res.field_end;
  assign result_out.message_end       = res.message_end;
  assign result_out.field_tag         = res.field_tag;
  assign result_out.value_byte        = res.value_byte;
  assign result_out.raw_value         = res.raw_value;
  assign result_out.computed_checksum = res.computed_checksum;
  assign result_out.received_checksum = res.received_checksum;
  assign result_out.checksum_ok       = res.checksum_ok;

endmodule

// File: rtl/core/tvmp_checker.sv
// Port-level checks for the tag=value message parser, and the bind that
// attaches them to the top level. Depends on tvmp_pkg.
`timescale 1ns / 1ps

module tvmp_checker
  import tvmp_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic                   value_valid,
  input logic                   field_end,
  input logic                   message_end,
  input logic [FIELD_TAG_W-1:0] field_tag,
  input logic [7:0]             value_byte,
  input logic [7:0]             computed_checksum,
  input logic [RX_CK_W-1:0]     received_checksum,
  input logic                   checksum_ok
);

  // nothing comes out the cycle after reset
  a_rst_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // a message end always closes a field; a raw checksum field may still
  // carry its last value byte on that beat
  a_msg_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && message_end |-> field_end)
    else $error("message end without field end");

  // checksum_ok only on a message end with matching sums
  a_ck_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && checksum_ok |->
      message_end && (received_checksum == RX_CK_W'(computed_checksum)))
    else $error("checksum_ok inconsistent");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      out_valid && $stable(field_tag) && $stable(value_byte) &&
      $stable(field_end) && $stable(computed_checksum))
    else $error("stalled result changed");

endmodule

bind tag_value_message_parser_top tvmp_checker u_tvmp_checker (
  .clk               (clk),
  .rst               (rst),
  .out_valid         (result_out.valid),
  .out_ready         (result_out.ready),
  .value_valid       (result_out.value_valid),
  .field_end         (result_out.field_end),
  .message_end       (result_out.message_end),
  .field_tag         (result_out.field_tag),
  .value_byte        (result_out.value_byte),
  .computed_checksum (result_out.computed_checksum),
  .received_checksum (result_out.received_checksum),
  .checksum_ok       (result_out.checksum_ok)
);
